@@ hdl/rapc_pkg.sv @@
// Package with the shared types, codes and constants of the RGBA alpha converter.
`timescale 1ns / 1ps
package rapc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned NumStages = 9;
  localparam int unsigned LastStage = NumStages - 1;
  localparam int unsigned Capacity = QueueDepth + NumStages;

  localparam logic [7:0] MaxChannel = 8'd255;
  localparam logic [16:0] PremulRound = 17'd127;
  localparam logic [33:0] PremulRecip = 34'd32897;
  localparam int unsigned PremulShift = 23;

  localparam logic [1:0] MODE_STRAIGHT = 2'd0;
  localparam logic [1:0] MODE_PREMUL = 2'd1;
  localparam logic [1:0] MODE_OPAQUE = 2'd2;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  localparam logic [1:0] CFG_SOURCE_MODE = 2'd0;
  localparam logic [1:0] CFG_TARGET_MODE = 2'd1;
  localparam logic [1:0] CFG_CHECK_CONTENT = 2'd2;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_PREMUL = 2'd1,
    OP_UNPREMUL = 2'd2
  } op_e;

  typedef struct packed {
    op_e op;
    logic err;
    logic [7:0] alpha;
    logic [2:0][7:0] chan;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] rem;
    logic [7:0] nlo;
    logic [7:0] quo;
    logic [15:0] prod;
    logic [7:0] pm;
  } lane_t;

  typedef struct packed {
    op_e op;
    logic err;
    logic [7:0] alpha;
    lane_t [2:0] lane;
  } stage_t;

endpackage

@@ hdl/rapc_if.sv @@
// Valid/ready channel interfaces for input pixels and converted pixels.
`timescale 1ns / 1ps
interface rapc_in_if;
  logic valid;
  logic ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source(output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rapc_out_if;
  logic valid;
  logic ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic content_error;

  modport source(output valid, red_out, green_out, blue_out, alpha_out, content_error,
                 input ready);
  modport sink(input valid, red_out, green_out, blue_out, alpha_out, content_error,
               output ready);
endinterface

@@ hdl/rgba_alpha_premultiply_convert.sv @@
// Top level of the RGBA alpha converter: front end, item queue and conversion pipeline.
// An accepted item is written into the queue, then passes pipeline stages 0 to 8 in order
// and is offered from the last; a stall holds them all. Throughput is one item per cycle
// while the output is ready, set by the nine-stage pipeline with a divider step in stages 1 to 8.
// Up to 13 items are held inside: four in the queue and nine in the pipeline.
// Reset clears the queue, the pipeline valid bits and the configuration registers.
`timescale 1ns / 1ps
module rgba_alpha_premultiply_convert (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  rapc_in_if.sink    in_if,
  rapc_out_if.source out_if
);
  import rapc_pkg::*;

  item_t push_item;
  item_t head_item;
  q_status_t q_status;
  logic push;
  logic pop;

  rapc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (push_item)
  );

  rapc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  rapc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_if     (out_if)
  );
endmodule

@@ hdl/rapc_front.sv @@
// Front end: configuration registers, item acceptance, content check and classification.
`timescale 1ns / 1ps
module rapc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [1:0]        cfg_data_i,
  rapc_in_if.sink           in_if,
  input  rapc_pkg::q_status_t q_status_i,
  output logic              push_o,
  output rapc_pkg::item_t   item_o
);
  import rapc_pkg::*;

  logic [1:0] src_q;
  logic tgt_q;
  logic chk_q;
  logic over;
  logic err;
  op_e op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= MODE_STRAIGHT;
      tgt_q <= 1'b1;
      chk_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_MODE: src_q <= cfg_data_i;
        CFG_TARGET_MODE: tgt_q <= cfg_data_i[0];
        CFG_CHECK_CONTENT: chk_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign over = (in_if.red_in > in_if.alpha_in) || (in_if.green_in > in_if.alpha_in) ||
                (in_if.blue_in > in_if.alpha_in);

  always_comb begin
    op = OP_PASS;
    err = 1'b0;
    if (src_q == MODE_UNDEF) begin
      err = 1'b1;
    end else begin
      if (chk_q && src_q != MODE_STRAIGHT) begin
        err = over || (src_q == MODE_OPAQUE && in_if.alpha_in != MaxChannel);
      end
      if (src_q != {1'b0, tgt_q} && src_q != MODE_OPAQUE) begin
        op = tgt_q ? OP_PREMUL : OP_UNPREMUL;
      end
    end
  end

  assign in_if.ready = !q_status_i.full;
  assign push_o = in_if.valid && !q_status_i.full;

  always_comb begin
    item_o.op = op;
    item_o.err = err;
    item_o.alpha = in_if.alpha_in;
    item_o.chan[0] = in_if.red_in;
    item_o.chan[1] = in_if.green_in;
    item_o.chan[2] = in_if.blue_in;
  end
endmodule

@@ hdl/rapc_fifo.sv @@
// Short item queue between the front end and the conversion pipeline.
`timescale 1ns / 1ps
module rapc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rapc_pkg::item_t     item_i,
  input  logic                pop_i,
  output rapc_pkg::item_t     head_o,
  output rapc_pkg::q_status_t status_o
);
  import rapc_pkg::*;

  item_t mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW:0] cnt_q, cnt_d;

  assign status_o.full = (cnt_q == (PtrW + 1)'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? PtrW'(wptr_q + 1'b1) : wptr_q;
    rptr_d = pop_i ? PtrW'(rptr_q + 1'b1) : rptr_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = (PtrW + 1)'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = (PtrW + 1)'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end
endmodule

@@ hdl/rapc_back.sv @@
// Back end: pipelined premultiply and bit-per-stage unpremultiply divider per channel.
`timescale 1ns / 1ps
module rapc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rapc_pkg::item_t     head_i,
  input  rapc_pkg::q_status_t q_status_i,
  output logic                pop_o,
  rapc_out_if.source          out_if
);
  import rapc_pkg::*;

  stage_t stage_q [NumStages];
  stage_t stage_d [NumStages];
  logic [NumStages-1:0] vld_q;
  logic adv;
  logic [7:0] res [3];

  always_comb begin
    logic [15:0] num;
    logic [8:0] r9;
    logic [16:0] y;
    logic [33:0] scaled;
    num = '0;
    r9 = '0;
    y = '0;
    scaled = '0;
    stage_d[0].op = head_i.op;
    stage_d[0].err = head_i.err;
    stage_d[0].alpha = head_i.alpha;
    for (int l = 0; l < 3; l++) begin
      num = {head_i.chan[l], 8'd0} - {8'd0, head_i.chan[l]} + {9'd0, head_i.alpha[7:1]};
      stage_d[0].lane[l].c = head_i.chan[l];
      stage_d[0].lane[l].rem = num[15:8];
      stage_d[0].lane[l].nlo = num[7:0];
      stage_d[0].lane[l].quo = '0;
      stage_d[0].lane[l].prod = 16'(head_i.chan[l]) * 16'(head_i.alpha);
      stage_d[0].lane[l].pm = '0;
    end
    for (int k = 1; k < NumStages; k++) begin
      stage_d[k] = stage_q[k-1];
      for (int l = 0; l < 3; l++) begin
        r9 = {stage_q[k-1].lane[l].rem, stage_q[k-1].lane[l].nlo[7]};
        if (r9 >= {1'b0, stage_q[k-1].alpha}) begin
          stage_d[k].lane[l].rem = 8'(r9 - {1'b0, stage_q[k-1].alpha});
          stage_d[k].lane[l].quo = {stage_q[k-1].lane[l].quo[6:0], 1'b1};
        end else begin
          stage_d[k].lane[l].rem = r9[7:0];
          stage_d[k].lane[l].quo = {stage_q[k-1].lane[l].quo[6:0], 1'b0};
        end
        stage_d[k].lane[l].nlo = {stage_q[k-1].lane[l].nlo[6:0], 1'b0};
        if (k == 1) begin
          y = {1'b0, stage_q[k-1].lane[l].prod} + PremulRound;
          scaled = 34'(y) * PremulRecip;
          stage_d[k].lane[l].pm = 8'(scaled >> PremulShift);
        end
      end
    end
  end

  assign adv = !vld_q[LastStage] || out_if.ready;
  assign pop_o = adv && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], !q_status_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumStages; k++) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      unique case (stage_q[LastStage].op)
        OP_PASS: res[l] = stage_q[LastStage].lane[l].c;
        OP_PREMUL: res[l] = stage_q[LastStage].lane[l].pm;
        OP_UNPREMUL: begin
          priority if (stage_q[LastStage].alpha == '0) begin
            res[l] = '0;
          end else if (stage_q[LastStage].lane[l].c >= stage_q[LastStage].alpha) begin
            res[l] = MaxChannel;
          end else begin
            res[l] = stage_q[LastStage].lane[l].quo;
          end
        end
        default: res[l] = stage_q[LastStage].lane[l].c;
      endcase
    end
  end

  assign out_if.valid = vld_q[LastStage];
  assign out_if.red_out = res[0];
  assign out_if.green_out = res[1];
  assign out_if.blue_out = res[2];
  assign out_if.alpha_out = stage_q[LastStage].alpha;
  assign out_if.content_error = stage_q[LastStage].err;
endmodule

@@ hdl/rapc_checker.sv @@
// Port-level checker for the RGBA alpha converter and its bind to the top level.
`timescale 1ns / 1ps
module rapc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i,
  input logic [7:0] alpha_i,
  input logic       err_i
);
  import rapc_pkg::*;

  logic [4:0] cnt_q;
  logic in_acc;
  logic out_acc;

  assign in_acc = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= 5'(cnt_q + {4'd0, in_acc} - {4'd0, out_acc});
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(red_i) && $stable(green_i) &&
      $stable(blue_i) && $stable(alpha_i) && $stable(err_i))
    else $error("Output item changed while stalled.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != 5'd0)
    else $error("Output item without an accepted input item.");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 5'(Capacity))
    else $error("More items in flight than the block can hold.");
endmodule

bind rgba_alpha_premultiply_convert rapc_checker u_rapc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .red_i       (out_if.red_out),
  .green_i     (out_if.green_out),
  .blue_i      (out_if.blue_out),
  .alpha_i     (out_if.alpha_out),
  .err_i       (out_if.content_error)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the RGBA alpha converter: directed table, then random pixels.
`timescale 1ns / 1ps
module tb_top;
  import rapc_pkg::*;

  localparam int unsigned NumPlan = 19;
  localparam int unsigned NumRandom = 1850;
  localparam int unsigned CalmFrom = 1650;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic content_error;
  } converted_t;

  typedef struct packed {
    logic [1:0] source;
    logic [1:0] target;
    logic check;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic known;
    logic [7:0] red_want;
    logic [7:0] green_want;
    logic [7:0] blue_want;
    logic err_want;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [1:0] cfg_data_i;

  rapc_in_if in_ch ();
  rapc_out_if out_ch ();

  rgba_alpha_premultiply_convert uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if(in_ch.sink),
    .out_if(out_ch.source)
  );

  logic [1:0] cur_source;
  logic [1:0] cur_target;
  logic cur_check;
  bit send_gaps;
  bit recv_stalls;
  int unsigned fail_count;
  int unsigned stall_cycles;
  converted_t expected_pixels[$];
  plan_row_t plan[NumPlan];

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] scale_channel(logic [7:0] c, logic [7:0] a, logic to_premul);
    int unsigned cv;
    int unsigned av;
    int unsigned v;
    cv = c;
    av = a;
    if (to_premul) begin
      v = (cv * 255 + 127) / 255;
      v = (cv * av + 127) / 255;
    end else if (av == 0) begin
      v = 0;
    end else begin
      v = (cv * 255 + av / 2) / av;
      if (v > 255) v = 255;
    end
    return v[7:0];
  endfunction

  function automatic converted_t convert_pixel(pixel_t px);
    converted_t res;
    logic [7:0] chan[3];
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    res.px = px;
    res.content_error = 1'b0;
    if (cur_source == MODE_UNDEF) begin
      res.content_error = 1'b1;
    end else begin
      if (cur_check && cur_source != MODE_STRAIGHT) begin
        if (cur_source == MODE_OPAQUE && px.alpha != MaxChannel) res.content_error = 1'b1;
        foreach (chan[i]) begin
          if (chan[i] > px.alpha) res.content_error = 1'b1;
        end
      end
      if (cur_source != cur_target && cur_source != MODE_OPAQUE) begin
        foreach (chan[i]) begin
          chan[i] = scale_channel(chan[i], px.alpha, cur_target == MODE_PREMUL);
        end
      end
    end
    res.px.red = chan[0];
    res.px.green = chan[1];
    res.px.blue = chan[2];
    return res;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    px.alpha = 8'($urandom_range(0, 255));
    px.red = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue = 8'($urandom_range(0, 255));
    case (kind)
      0, 1, 2, 3: begin
        px.red = 8'($urandom_range(0, px.alpha));
        px.green = 8'($urandom_range(0, px.alpha));
        px.blue = 8'($urandom_range(0, px.alpha));
      end
      4: px.alpha = MaxChannel;
      5: px.alpha = 8'd0;
      6: begin
        px.red = px.alpha + 8'($urandom_range(0, 2)) - 8'd1;
        px.green = px.alpha + 8'($urandom_range(0, 2)) - 8'd1;
        px.blue = px.alpha + 8'($urandom_range(0, 2)) - 8'd1;
      end
      7: begin
        px.red = $urandom_range(0, 1) ? MaxChannel : 8'd0;
        px.green = $urandom_range(0, 1) ? MaxChannel : 8'd0;
        px.blue = $urandom_range(0, 1) ? MaxChannel : 8'd0;
        px.alpha = $urandom_range(0, 1) ? MaxChannel : 8'd0;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      CFG_SOURCE_MODE: cur_source = data;
      CFG_TARGET_MODE: cur_target = {1'b0, data[0]};
      CFG_CHECK_CONTENT: cur_check = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_pixel(input pixel_t px, input logic known, input converted_t want);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.red_in = px.red;
    in_ch.green_in = px.green;
    in_ch.blue_in = px.blue;
    in_ch.alpha_in = px.alpha;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    expected_pixels.push_back(known ? want : convert_pixel(px));
    @(negedge clk_i);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (recv_stalls && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    converted_t got;
    converted_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.px.red = out_ch.red_out;
      got.px.green = out_ch.green_out;
      got.px.blue = out_ch.blue_out;
      got.px.alpha = out_ch.alpha_out;
      got.content_error = out_ch.content_error;
      if (expected_pixels.size() == 0) begin
        if (fail_count < MaxReports) begin
          $display("Unexpected pixel at %0t: rgba %h %h %h %h error %b", $realtime,
                   got.px.red, got.px.green, got.px.blue, got.px.alpha, got.content_error);
        end
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          if (fail_count < MaxReports) begin
            $display("Pixel mismatch at %0t: expected rgba %h %h %h %h error %b, got %h %h %h %h error %b",
                     $realtime, want.px.red, want.px.green, want.px.blue, want.px.alpha,
                     want.content_error, got.px.red, got.px.green, got.px.blue,
                     got.px.alpha, got.content_error);
          end
          fail_count++;
        end
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned sent_count;
    int unsigned phase_len;
    pixel_t px;
    converted_t want;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SOURCE_MODE;
    cfg_data_i = MODE_STRAIGHT;
    in_ch.valid = 1'b0;
    in_ch.red_in = 8'd0;
    in_ch.green_in = 8'd0;
    in_ch.blue_in = 8'd0;
    in_ch.alpha_in = 8'd0;
    cur_source = MODE_STRAIGHT;
    cur_target = MODE_PREMUL;
    cur_check = 1'b0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    fail_count = 0;

    // Columns: source, target, check, pixel in, expected known, expected rgb and error.
    plan[0] = '{MODE_STRAIGHT, MODE_PREMUL, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255,
                1'b1, 8'd255, 8'd255, 8'd255, 1'b0};
    plan[1] = '{MODE_STRAIGHT, MODE_PREMUL, 1'b0, 8'd255, 8'd128, 8'd0, 8'd0,
                1'b1, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[2] = '{MODE_STRAIGHT, MODE_PREMUL, 1'b0, 8'd200, 8'd100, 8'd50, 8'd128,
                1'b0, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[3] = '{MODE_STRAIGHT, MODE_PREMUL, 1'b0, 8'd1, 8'd254, 8'd127, 8'd1,
                1'b0, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[4] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b0, 8'd10, 8'd20, 8'd30, 8'd0,
                1'b1, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[5] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255,
                1'b1, 8'd255, 8'd255, 8'd255, 1'b0};
    plan[6] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b0, 8'd200, 8'd10, 8'd255, 8'd100,
                1'b0, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[7] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b0, 8'd1, 8'd0, 8'd1, 8'd1,
                1'b0, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[8] = '{MODE_PREMUL, MODE_PREMUL, 1'b1, 8'd10, 8'd20, 8'd30, 8'd40,
                1'b1, 8'd10, 8'd20, 8'd30, 1'b0};
    plan[9] = '{MODE_PREMUL, MODE_PREMUL, 1'b1, 8'd50, 8'd20, 8'd30, 8'd40,
                1'b1, 8'd50, 8'd20, 8'd30, 1'b1};
    plan[10] = '{MODE_OPAQUE, MODE_STRAIGHT, 1'b1, 8'd1, 8'd2, 8'd3, 8'd255,
                 1'b1, 8'd1, 8'd2, 8'd3, 1'b0};
    plan[11] = '{MODE_OPAQUE, MODE_STRAIGHT, 1'b1, 8'd1, 8'd2, 8'd3, 8'd254,
                 1'b1, 8'd1, 8'd2, 8'd3, 1'b1};
    plan[12] = '{MODE_OPAQUE, MODE_PREMUL, 1'b0, 8'd100, 8'd200, 8'd50, 8'd7,
                 1'b1, 8'd100, 8'd200, 8'd50, 1'b0};
    plan[13] = '{MODE_UNDEF, MODE_STRAIGHT, 1'b0, 8'd12, 8'd34, 8'd56, 8'd78,
                 1'b1, 8'd12, 8'd34, 8'd56, 1'b1};
    plan[14] = '{MODE_UNDEF, MODE_PREMUL, 1'b1, 8'd255, 8'd0, 8'd255, 8'd0,
                 1'b1, 8'd255, 8'd0, 8'd255, 1'b1};
    plan[15] = '{MODE_STRAIGHT, MODE_STRAIGHT, 1'b1, 8'd255, 8'd255, 8'd255, 8'd0,
                 1'b1, 8'd255, 8'd255, 8'd255, 1'b0};
    plan[16] = '{MODE_STRAIGHT, MODE_PREMUL, 1'b1, 8'd255, 8'd1, 8'd2, 8'd3,
                 1'b0, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[17] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0,
                 1'b1, 8'd0, 8'd0, 8'd0, 1'b0};
    plan[18] = '{MODE_PREMUL, MODE_STRAIGHT, 1'b1, 8'd255, 8'd0, 8'd0, 8'd254,
                 1'b0, 8'd0, 8'd0, 8'd0, 1'b0};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].source != cur_source || plan[k].target != cur_target ||
          plan[k].check != cur_check) begin
        wait_idle();
        if (plan[k].source != cur_source) write_reg(CFG_SOURCE_MODE, plan[k].source);
        if (plan[k].target != cur_target) write_reg(CFG_TARGET_MODE, plan[k].target);
        if (plan[k].check != cur_check) write_reg(CFG_CHECK_CONTENT, {1'b0, plan[k].check});
      end
      px = '{plan[k].red, plan[k].green, plan[k].blue, plan[k].alpha};
      want = '{'{plan[k].red_want, plan[k].green_want, plan[k].blue_want, plan[k].alpha},
               plan[k].err_want};
      send_pixel(px, plan[k].known, want);
    end

    sent_count = 0;
    while (sent_count < NumRandom) begin
      wait_idle();
      write_reg(CFG_SOURCE_MODE, 2'($urandom_range(0, 3)));
      write_reg(CFG_TARGET_MODE, 2'($urandom_range(0, 1)));
      write_reg(CFG_CHECK_CONTENT, 2'($urandom_range(0, 1)));
      send_gaps = (sent_count < CalmFrom) && ($urandom_range(0, 3) != 0);
      recv_stalls = (sent_count < CalmFrom) && ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 100);
      repeat (phase_len) begin
        send_pixel(random_pixel(), 1'b0, '0);
        sent_count++;
      end
    end

    in_ch.valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rapc_pkg.sv
hdl/rapc_if.sv
hdl/rapc_front.sv
hdl/rapc_fifo.sv
hdl/rapc_back.sv
hdl/rgba_alpha_premultiply_convert.sv
hdl/rapc_checker.sv
tb/tb_top.sv
